FILE: hdl/i2cms_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
package i2cms_pkg;
  localparam int NumBuses = 3;
  localparam int BufferBytes = 256;
  localparam int BusW = 2;
  localparam int PosW = 9;
  localparam int BufAw = $clog2(NumBuses * BufferBytes);
  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [3:0] {
    PH_IDLE, PH_W_START, PH_W_ADDR, PH_W_DATA, PH_W_STOP,
    PH_R_START, PH_R_ADDR, PH_R_DATA, PH_R_NACK, PH_R_ACK, PH_R_STOP,
    PH_RR_START, PH_RR_ADDR, PH_RR_WRITE, PH_RR_RESTART
  } phase_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_WRITE, OP_REG_WRITE, OP_READ, OP_REG_READ, OP_EVENT, OP_NOP6, OP_NOP7
  } opcode_t;

  typedef enum logic [1:0] {K_STATUS, K_ACTION, K_RX, K_DONE} kind_t;

  typedef enum logic [2:0] {
    A_NONE, A_START, A_TX, A_RCEN, A_ACK, A_NACK, A_STOP, A_RESTART
  } action_t;

  typedef enum logic [1:0] {ST_OK, ST_BUSY, ST_INVALID, ST_RSVD} status_t;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_OUT0, S_OUT1} ctl_state_t;

  typedef struct packed {
    logic capture;
    logic buf_read;
    logic exec;
    logic emit0;
    logic emit1;
  } ctl_cmd_t;

  typedef struct packed {
    logic two_results;
    logic no_result;
    logic out_busy;
  } ctl_stat_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] status;
    logic [1:0] bus_id;
    logic [2:0] bus_action;
    logic [7:0] transmit_byte;
    logic [7:0] rx_data;
    logic [7:0] rx_index;
    logic       done_is_read;
    logic [6:0] done_address;
    logic [7:0] done_register;
    logic [8:0] done_length;
    logic       last_of_run;
  } result_t;
endpackage

FILE: hdl/i2cms_ctrl.sv
// Controller state machine that steps one item through read, execute and output.
module i2cms_ctrl
  import i2cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);
  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = S_EXEC;
      S_EXEC: state_next = stat.no_result ? S_IDLE : S_OUT0;
      S_OUT0: if (!stat.out_busy) state_next = stat.two_results ? S_OUT1 : S_IDLE;
      S_OUT1: if (!stat.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      S_READ: cmd.buf_read = 1'b1;
      S_EXEC: cmd.exec = 1'b1;
      S_OUT0: cmd.emit0 = !stat.out_busy;
      S_OUT1: cmd.emit1 = !stat.out_busy;
      default: ;
    endcase
  end
endmodule

FILE: hdl/i2cms_datapath.sv
// Datapath with per-bus state, the byte buffer and the result register.
module i2cms_datapath
  import i2cms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic [52:0] in_data,
  input  ctl_cmd_t  cmd,
  output ctl_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);
  logic [2:0] op;
  logic [1:0] bus;
  logic [6:0] addr_in;
  logic [7:0] reg_in, ld_val, ld_idx, rx_in;
  logic [8:0] len_in;

  phase_t     phase [NumBuses];
  logic [PosW-1:0] position [NumBuses];
  logic [PosW-1:0] len_held [NumBuses];
  logic [6:0] addr_held [NumBuses];
  logic [7:0] reg_held [NumBuses];

  logic [7:0] mem [NumBuses * BufferBytes];
  logic [7:0] rd_data;

  result_t r0, r1;
  logic two;

  logic bus_ok;
  logic [BusW-1:0] b;
  phase_t ph;
  logic [PosW-1:0] pos, lh;
  logic [BufAw-1:0] base;
  logic is_start, len_bad, start_ok;

  assign bus_ok = (bus != '0) && ({1'b0, bus} <= 3'(NumBuses));
  assign b = bus - 2'd1;
  assign ph = phase[b];
  assign pos = position[b];
  assign lh = len_held[b];
  assign base = BufAw'(b) * BufAw'(BufferBytes);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= in_data[2:0];
      bus <= in_data[4:3];
      addr_in <= in_data[11:5];
      reg_in <= in_data[19:12];
      len_in <= in_data[28:20];
      ld_val <= in_data[36:29];
      ld_idx <= in_data[44:37];
      rx_in <= in_data[52:45];
    end
  end

  // Buffer read address: position for the event path, zero for every other opcode, such as a plain write.
  logic [PosW-1:0] rd_pos;
  assign rd_pos = (opcode_t'(op) == OP_EVENT) ? pos : '0;

  always_ff @(posedge clk) begin
    if (cmd.buf_read) rd_data <= (rd_pos < PosW'(BufferBytes)) ?
                                 mem[base + BufAw'(rd_pos)] : 8'h00;
  end

  logic wr_en;
  logic [PosW-1:0] wr_pos;
  logic [7:0] wr_val;
  logic ev_rx;

  assign ev_rx = (opcode_t'(op) == OP_EVENT) && bus_ok && (ph == PH_R_DATA);

  always_comb begin
    wr_en = 1'b0;
    wr_pos = '0;
    wr_val = ld_val;
    if (bus_ok) begin
      if (opcode_t'(op) == OP_LOAD) begin
        wr_en = 1'b1;
        wr_pos = PosW'(ld_idx);
      end else if (ev_rx) begin
        wr_en = 1'b1;
        wr_pos = pos;
        wr_val = rx_in;
      end else if (opcode_t'(op) == OP_REG_WRITE && start_ok) begin
        wr_en = 1'b1;
        wr_val = reg_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en && wr_pos < PosW'(BufferBytes))
      mem[base + BufAw'(wr_pos)] <= wr_val;
  end

  assign is_start = (op >= 3'd1) && (op <= 3'd4);
  assign len_bad = (len_in == '0) || ({1'b0, len_in} > 10'(BufferBytes)) ||
                   ((opcode_t'(op) == OP_REG_WRITE) &&
                    ({1'b0, len_in} + 10'd1 > 10'(BufferBytes)));
  assign start_ok = is_start && bus_ok && (ph == PH_IDLE) && !len_bad;

  result_t n0, n1;
  logic n_two, n_none;
  phase_t ph_n;
  logic [PosW-1:0] pos_n;
  logic [PosW-1:0] pos_inc;
  assign pos_inc = pos + 1'b1;

  always_comb begin
    n0 = '0;
    n1 = '0;
    n0.bus_id = bus;
    n1.bus_id = bus;
    n_two = 1'b0;
    n_none = 1'b0;
    ph_n = ph;
    pos_n = pos;
    if (is_start) begin
      n0.result_kind = K_STATUS;
      if (!bus_ok) n0.status = ST_INVALID;
      else if (ph != PH_IDLE) n0.status = ST_BUSY;
      else if (len_bad) n0.status = ST_INVALID;
      else begin
        n0.status = ST_OK;
        n_two = 1'b1;
        n1.result_kind = K_ACTION;
        n1.bus_action = A_START;
        pos_n = '0;
        unique case (opcode_t'(op))
          OP_READ: ph_n = PH_R_START;
          OP_REG_READ: ph_n = PH_RR_START;
          default: ph_n = PH_W_START;
        endcase
      end
    end else if (opcode_t'(op) == OP_EVENT && bus_ok && ph != PH_IDLE) begin
      n0.result_kind = K_ACTION;
      unique case (ph)
        PH_W_START: begin
          ph_n = PH_W_ADDR;
          n0.bus_action = A_TX;
          n0.transmit_byte = {addr_held[b], 1'b0};
        end
        PH_W_ADDR, PH_W_DATA: begin
          if (pos >= lh) begin
            ph_n = PH_W_STOP;
            n0.bus_action = A_STOP;
          end else begin
            ph_n = PH_W_DATA;
            n0.bus_action = A_TX;
            n0.transmit_byte = rd_data;
            pos_n = pos_inc;
          end
        end
        PH_W_STOP, PH_R_STOP: begin
          n0.result_kind = K_DONE;
          n0.done_is_read = (ph == PH_R_STOP);
          n0.done_address = addr_held[b];
          n0.done_register = reg_held[b];
          n0.done_length = lh;
          ph_n = PH_IDLE;
        end
        PH_R_START, PH_RR_RESTART: begin
          ph_n = PH_R_ADDR;
          n0.bus_action = A_TX;
          n0.transmit_byte = {addr_held[b], 1'b0} | ReadBit;
        end
        PH_R_ADDR, PH_R_ACK: begin
          ph_n = PH_R_DATA;
          n0.bus_action = A_RCEN;
        end
        PH_R_DATA: begin
          n0.result_kind = K_RX;
          n0.rx_data = rx_in;
          n0.rx_index = pos[7:0];
          pos_n = pos_inc;
          n_two = 1'b1;
          n1.result_kind = K_ACTION;
          if (pos_inc < lh) begin
            n1.bus_action = A_ACK;
            ph_n = PH_R_ACK;
          end else begin
            n1.bus_action = A_NACK;
            ph_n = PH_R_NACK;
          end
        end
        PH_R_NACK: begin
          ph_n = PH_R_STOP;
          n0.bus_action = A_STOP;
        end
        PH_RR_START: begin
          ph_n = PH_RR_ADDR;
          n0.bus_action = A_TX;
          n0.transmit_byte = {addr_held[b], 1'b0};
        end
        PH_RR_ADDR: begin
          ph_n = PH_RR_WRITE;
          n0.bus_action = A_TX;
          n0.transmit_byte = reg_held[b];
        end
        PH_RR_WRITE: begin
          ph_n = PH_RR_RESTART;
          n0.bus_action = A_RESTART;
        end
        default: n_none = 1'b1;
      endcase
    end else begin
      n_none = 1'b1;
    end
    n0.last_of_run = !n_two;
    n1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumBuses; i++) begin
        phase[i] <= PH_IDLE;
        position[i] <= '0;
        len_held[i] <= '0;
        addr_held[i] <= '0;
        reg_held[i] <= '0;
      end
    end else if (cmd.exec && bus_ok) begin
      phase[b] <= ph_n;
      position[b] <= pos_n;
      if (start_ok) begin
        addr_held[b] <= addr_in;
        unique case (opcode_t'(op))
          OP_WRITE: begin
            len_held[b] <= len_in;
            reg_held[b] <= rd_data + len_in[7:0] - 8'd1;
          end
          OP_REG_WRITE: begin
            len_held[b] <= len_in + 9'd1;
            reg_held[b] <= reg_in + len_in[7:0] - 8'd1;
          end
          OP_REG_READ: begin
            len_held[b] <= len_in;
            reg_held[b] <= reg_in;
          end
          default: len_held[b] <= len_in;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r0 <= n0;
      r1 <= n1;
      two <= n_two;
    end
  end

  assign stat.no_result = n_none;
  assign stat.two_results = two;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit0 || cmd.emit1) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit0) out_res <= r0;
    else if (cmd.emit1) out_res <= r1;
  end
endmodule

FILE: hdl/i2c_master_transfer_sequencer_unit.sv
// Top level of the I2C master transfer sequencer.
// An item with results presents its first result once it has passed the read, execute
// and first output states and the output register. A new item is accepted only in the
// idle state, after all results of the last one are out; output stalls add to the wait.
// The buffer read and the per-bus update are done in separate steps.
// Reset (rst, synchronous) idles all buses; the byte buffer is not cleared.
module i2c_master_transfer_sequencer_unit
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, bus_select, target_address, register_index, transfer_length,
  // load_value, load_index, received_byte
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_kind, status, bus_id, bus_action, transmit_byte, rx_data, rx_index,
  // done_is_read, done_address, done_register, done_length
  output logic [63:0] m_tdata,
  output logic        m_tlast
);
  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  result_t   res;

  i2cms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  i2cms_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(s_tdata[52:0]),
    .cmd(cmd), .stat(stat), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_res(res)
  );

  assign m_tdata = {6'd0, res.done_length, res.done_register, res.done_address,
                    res.done_is_read, res.rx_index, res.rx_data, res.transmit_byte,
                    res.bus_action, res.bus_id, res.status, res.result_kind};
  assign m_tlast = res.last_of_run;
endmodule

FILE: hdl/i2cms_checker.sv
// Port checker for the I2C master transfer sequencer, bound to the top level.
module i2cms_checker
  import i2cms_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");
  a_noaccept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted on back-to-back cycles");
  a_status_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == K_STATUS && m_tdata[3:2] == ST_OK |-> !m_tlast)
    else $error("accepted status ended a run");
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
endmodule

bind i2c_master_transfer_sequencer_unit i2cms_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
